[design/tru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE unpacker package
// Register indexes, stream constants and the types shared by the modules.
// ----------------------------------------------------------------------------
package tru_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RLE_MODE    = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL = 8'd2;

	// Bytes per pixel, coded as count minus one.
	localparam logic [1:0] PB_ONE   = 2'd0;
	localparam logic [1:0] PB_TWO   = 2'd1;
	localparam logic [1:0] PB_THREE = 2'd2;
	localparam logic [1:0] PB_FOUR  = 2'd3;

	localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
	localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;
	localparam logic [15:0] RAW16_MASK    = 16'h7FFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef struct packed {
		logic [1:0] pb_m1;
		logic       rle;
	} tru_mode_t;

	// One assembled pixel on its way from the parser to the output stage.
	typedef struct packed {
		logic [31:0] raw;
		logic [7:0]  count;
		logic        done;
		tru_mode_t   mode;
	} tru_item_t;

endpackage
`default_nettype wire

[design/tru_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE unpacker channels
// Valid/ready interfaces for the byte stream, the pixel stream and config.
// ----------------------------------------------------------------------------
interface tru_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface tru_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        image_done;
	modport source (output valid, output pixel_value, output repeat_count,
		output image_done, input ready);
	modport sink   (input valid, input pixel_value, input repeat_count,
		input image_done, output ready);
endinterface

interface tru_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_index;
	logic [31:0] wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

[design/tru_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE unpacker front end
// Parses packet headers, assembles pixel bytes and tracks the image count.
// ----------------------------------------------------------------------------
module tru_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_data,
	output logic                   in_ready,
	input  wire tru_pkg::tru_mode_t mode,
	input  wire logic [31:0]       total_eff,
	input  wire logic              restart,
	input  wire logic              q_ready,
	output logic                   q_push,
	output tru_pkg::tru_item_t     q_item
);
	import tru_pkg::*;

	logic [31:0] left_q, left_n;
	logic [7:0]  pkt_q, pkt_n;
	logic        run_q, run_n;
	logic [1:0]  pos_q, pos_n;
	logic [31:0] asm_q, asm_n;
	logic [9:0]  skip_q, skip_n;

	logic        fire;
	logic [31:0] asm_new;
	logic [7:0]  cnt;
	logic [7:0]  cnt_clip;
	logic        done;
	logic [7:0]  pkt_after;
	logic [9:0]  skip_len;
	logic        is_run;

	assign in_ready = q_ready;
	assign fire     = in_valid && in_ready;
	assign is_run   = mode.rle && run_q;
	assign asm_new  = asm_q | ({24'd0, in_data} << {pos_q, 3'b000});
	assign cnt      = is_run ? pkt_q : 8'd1;
	assign done     = (left_q <= {24'd0, cnt});
	assign cnt_clip = ({24'd0, cnt} > left_q) ? left_q[7:0] : cnt;
	assign pkt_after = is_run ? 8'd0 : (mode.rle ? pkt_q - 8'd1 : pkt_q);

	always_comb begin
		case (mode.pb_m1)
			PB_ONE:   skip_len = {2'b00, pkt_after};
			PB_TWO:   skip_len = {1'b0, pkt_after, 1'b0};
			PB_THREE: skip_len = {1'b0, pkt_after, 1'b0} + {2'b00, pkt_after};
			PB_FOUR:  skip_len = {pkt_after, 2'b00};
			default:  skip_len = {2'b00, pkt_after};
		endcase
	end

	always_comb begin
		left_n = left_q;
		pkt_n  = pkt_q;
		run_n  = run_q;
		pos_n  = pos_q;
		asm_n  = asm_q;
		skip_n = skip_q;
		q_push = 1'b0;
		q_item.raw   = asm_new;
		q_item.count = cnt_clip;
		q_item.done  = done;
		q_item.mode  = mode;
		if (restart) begin
			left_n = total_eff;
			pkt_n  = 8'd0;
			run_n  = 1'b0;
			pos_n  = 2'd0;
			asm_n  = 32'd0;
			skip_n = 10'd0;
		end else if (fire) begin
			if (skip_q != 10'd0) begin
				skip_n = skip_q - 10'd1;
				if (skip_q == 10'd1) begin
					left_n = total_eff;
					pkt_n  = 8'd0;
					run_n  = 1'b0;
					pos_n  = 2'd0;
					asm_n  = 32'd0;
				end
			end else if (mode.rle && pkt_q == 8'd0) begin
				run_n = (in_data & HDR_RUN_MASK) != 8'd0;
				pkt_n = (in_data & HDR_COUNT_MASK) + 8'd1;
			end else if (pos_q < mode.pb_m1) begin
				pos_n = pos_q + 2'd1;
				asm_n = asm_new;
			end else begin
				q_push = 1'b1;
				asm_n  = 32'd0;
				pos_n  = 2'd0;
				pkt_n  = pkt_after;
				left_n = left_q - {24'd0, cnt_clip};
				if (done) begin
					if (mode.rle && !run_q && pkt_after != 8'd0) begin
						// Image ended inside a literal packet: swallow its tail.
						skip_n = skip_len;
						pkt_n  = 8'd0;
					end else begin
						left_n = total_eff;
						pkt_n  = 8'd0;
						run_n  = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 32'd1;
			pkt_q  <= 8'd0;
			run_q  <= 1'b0;
			pos_q  <= 2'd0;
			asm_q  <= 32'd0;
			skip_q <= 10'd0;
		end else begin
			left_q <= left_n;
			pkt_q  <= pkt_n;
			run_q  <= run_n;
			pos_q  <= pos_n;
			asm_q  <= asm_n;
			skip_q <= skip_n;
		end
	end

endmodule
`default_nettype wire

[design/tru_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE unpacker queue
// Two-entry FIFO that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module tru_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tru_pkg::tru_item_t push_item,
	output logic                    ready,
	input  wire logic               pop,
	output logic                    valid,
	output tru_pkg::tru_item_t      item
);
	import tru_pkg::*;

	tru_item_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q;
	logic [QUEUE_PTR_W-1:0] rd_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign ready = cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[design/tru_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TGA RLE unpacker back end
// Reorders 3- and 4-byte pixels into RGBA layout and holds the result for transfer.
// ----------------------------------------------------------------------------
module tru_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire tru_pkg::tru_item_t q_item,
	output logic                    q_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             pixel_value,
	output logic [7:0]              repeat_count,
	output logic                    image_done
);
	import tru_pkg::*;

	logic        valid_q;
	logic [31:0] value_q;
	logic [7:0]  count_q;
	logic        done_q;
	logic [31:0] fmt;
	logic [31:0] raw;

	assign raw = q_item.raw;

	always_comb begin
		case (q_item.mode.pb_m1)
			PB_ONE:   fmt = {24'd0, raw[7:0]};
			PB_TWO:   fmt = q_item.mode.rle ? {16'd0, raw[15:0]}
				: {16'd0, raw[15:0] & RAW16_MASK};
			PB_THREE: fmt = {8'd0, raw[7:0], raw[15:8], raw[23:16]};
			PB_FOUR:  fmt = {raw[31:24], raw[7:0], raw[15:8], raw[23:16]};
			default:  fmt = {24'd0, raw[7:0]};
		endcase
	end

	assign q_pop        = q_valid && (!valid_q || out_ready);
	assign out_valid    = valid_q;
	assign pixel_value  = value_q;
	assign repeat_count = count_q;
	assign image_done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q <= fmt;
			count_q <= q_item.count;
			done_q  <= q_item.done;
		end
	end

endmodule
`default_nettype wire

[design/tga_rle_pixel_unpacker.sv]
`timescale 1ns / 1ps
`default_nettype none
// The byte that completes a pixel is written into the queue at its transfer
// edge and moves on into the output register once the back end can take it.
// Throughput: one byte per cycle while the queue has room, bounded by the single-byte parser step.
// Reset: asynchronous, active low; registers take 1 byte per pixel, RLE
// mode on and a one-pixel image, and the parser waits for a packet header.
// ----------------------------------------------------------------------------
// TGA RLE pixel unpacker
// Decodes a TGA run-length or raw pixel byte stream into RGBA pixels.
// ----------------------------------------------------------------------------
module tga_rle_pixel_unpacker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tru_byte_if.sink    stream,
	tru_pixel_if.source pixels,
	tru_cfg_if.sink     cfg
);
	import tru_pkg::*;

	// Configuration registers. The port is always ready; writes must be issued
	// only while the block is idle (the block does not enforce this), and every
	// known write restarts the image as if the previous one had just completed.
	logic [2:0]  pixel_bytes_q;
	logic        rle_mode_q;
	logic [31:0] pixel_total_q;

	logic        cfg_fire;
	logic        cfg_known;
	logic [31:0] total_next;
	logic [31:0] total_eff;
	tru_mode_t   mode;

	tru_item_t   push_item;
	logic        push;
	logic        q_ready;
	logic        q_valid;
	logic        q_pop;
	tru_item_t   q_item;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg_known = cfg_fire && (cfg.reg_index == REG_PIXEL_BYTES
		|| cfg.reg_index == REG_RLE_MODE || cfg.reg_index == REG_PIXEL_TOTAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= 3'd1;
			rle_mode_q    <= 1'b1;
			pixel_total_q <= 32'd1;
		end else if (cfg_fire) begin
			case (cfg.reg_index)
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg.wdata[2:0];
				REG_RLE_MODE:    rle_mode_q    <= cfg.wdata[0];
				REG_PIXEL_TOTAL: pixel_total_q <= cfg.wdata;
				default:         pixel_total_q <= pixel_total_q;
			endcase
		end
	end

	// The restart that a write causes must load the pixel count being
	// written, so the parser sees the value the register is about to take.
	assign total_next = (cfg_fire && cfg.reg_index == REG_PIXEL_TOTAL)
		? cfg.wdata : pixel_total_q;
	assign total_eff  = (total_next == 32'd0) ? 32'd1 : total_next;

	// A byte count of zero behaves as one, anything above four as four.
	always_comb begin
		mode.rle = rle_mode_q;
		case (pixel_bytes_q)
			3'd0:    mode.pb_m1 = PB_ONE;
			3'd1:    mode.pb_m1 = PB_ONE;
			3'd2:    mode.pb_m1 = PB_TWO;
			3'd3:    mode.pb_m1 = PB_THREE;
			default: mode.pb_m1 = PB_FOUR;
		endcase
	end

	// The front end takes one byte per transfer and pushes a finished pixel
	// into the queue; it stalls only when the queue is full.
	tru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stream.valid),
		.in_data   (stream.data_byte),
		.in_ready  (stream.ready),
		.mode      (mode),
		.total_eff (total_eff),
		.restart   (cfg_known),
		.q_ready   (q_ready),
		.q_push    (push),
		.q_item    (push_item)
	);

	tru_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_item)
	);

	// The back end formats the pixel and holds it in the output register
	// until the downstream transfer completes.
	tru_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (pixels.valid),
		.out_ready    (pixels.ready),
		.pixel_value  (pixels.pixel_value),
		.repeat_count (pixels.repeat_count),
		.image_done   (pixels.image_done)
	);

endmodule
`default_nettype wire
